FILE: sv/rbrl_pkg.sv
// Shared types, widths and the binomial table function for the RRR block rank lookup.
package rbrl_pkg;

    localparam int CLASS_W  = 4;
    localparam int OFFSET_W = 13;
    localparam int POS_W    = 4;
    localparam int RANK_W   = 4;
    // One bit above the offset so a saturated coefficient beats every offset.
    localparam int BINOM_W  = OFFSET_W + 1;
    localparam int CLASS_N  = 1 << CLASS_W;
    // Wide enough for any bit index of a block up to 63 bits.
    localparam int IDX_W    = 7;

    localparam logic [BINOM_W-1:0] BINOM_CAP = BINOM_W'(1) << OFFSET_W;

    // Decode state handed from cell to cell.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [CLASS_W-1:0]  remaining;
        logic [RANK_W-1:0]   rank;
        logic [POS_W-1:0]    pos;
        logic                bad;
    } cell_data_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              bad;
    } result_t;

    // C(n, k) saturated at BINOM_CAP, built from Pascal's rule; 0 when k > n.
    function automatic logic [BINOM_W-1:0] binom_sat(input int n, input int k);
        logic [BINOM_W-1:0] row [CLASS_N];
        logic [BINOM_W:0]   s;
        int                 i;
        int                 j;
        for (j = 0; j < CLASS_N; j++) begin
            row[j] = '0;
        end
        row[0] = BINOM_W'(1);
        for (i = 1; i <= n; i++) begin
            for (j = CLASS_N - 1; j >= 1; j--) begin
                s = {1'b0, row[j]} + {1'b0, row[j-1]};
                row[j] = (s >= {1'b0, BINOM_CAP}) ? BINOM_CAP : s[BINOM_W-1:0];
            end
        end
        if (k > n || k >= CLASS_N) begin
            return '0;
        end
        return row[k];
    endfunction

endpackage

FILE: sv/rrr_block_rank_lookup_unit.sv
// Top level of the RRR block rank lookup: entry stage, decode cell chain, output buffer.
//
// Rank of an RRR-coded block. Each request carries a class (popcount of a
// BLOCK_BITS-bit block), an offset among all blocks of that class in
// ascending numeric order, and a bit position; the result is the number of
// ones in bits 0..position of the decoded block, plus a bad_request flag when
// the class exceeds BLOCK_BITS or the offset is not below C(BLOCK_BITS, class)
// (rank is then 0). Decoding is enumerative, MSB first, over a chain of
// BLOCK_BITS identical cells, one per bit: a cell compares the running offset
// with the constant C(p, ones_left), subtracts and counts on a hit, and
// registers the state for its neighbor. One request is accepted per cycle
// while in_ready is high, and results come out in order. From accept to
// out_valid a request passes the entry stage register, one register per
// cell, then the output register. The whole chain advances together;
// in_ready is the output buffer's registered "skid entry free" flag, so
// requests keep flowing while one result waits, and the chain holds only
// once a second finished result is parked.
// Positions at or beyond the block end simply count the whole block.
module rrr_block_rank_lookup_unit #(
    parameter int BLOCK_BITS = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rbrl_pkg::CLASS_W-1:0]  block_class,
    input  logic [rbrl_pkg::OFFSET_W-1:0] class_offset,
    input  logic [rbrl_pkg::POS_W-1:0]    bit_position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rbrl_pkg::RANK_W-1:0]   rank_value,
    output logic                          bad_request
);

    // Chain enable: every stage shifts together when the buffer can take one.
    logic                         en;

    // stage 0 is the entry register, stage i+1 the output of cell i
    logic                         stage_valid [BLOCK_BITS+1];
    rbrl_pkg::cell_data_t         stage_data  [BLOCK_BITS+1];

    // C(BLOCK_BITS, k), 0 for k above the block size, so one compare covers both checks
    logic [rbrl_pkg::BINOM_W-1:0] total_tbl [rbrl_pkg::CLASS_N];
    logic                         entry_bad;
    rbrl_pkg::cell_data_t         entry_next;
    rbrl_pkg::result_t            chain_result;
    rbrl_pkg::result_t            out_result;

    for (genvar k = 0; k < rbrl_pkg::CLASS_N; k++) begin : g_total
        assign total_tbl[k] = rbrl_pkg::binom_sat(BLOCK_BITS, k);
    end

    assign entry_bad = {1'b0, class_offset} >= total_tbl[block_class];

    always_comb begin
        entry_next.offset    = class_offset;
        // a bad request walks the chain with nothing left to place: rank stays 0
        entry_next.remaining = entry_bad ? '0 : block_class;
        entry_next.rank      = '0;
        entry_next.pos       = bit_position;
        entry_next.bad       = entry_bad;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stage_valid[0] <= 1'b0;
        end else if (en) begin
            stage_valid[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            stage_data[0] <= entry_next;
        end
    end

    // Cell i resolves bit BLOCK_BITS-1-i, most significant first.
    for (genvar i = 0; i < BLOCK_BITS; i++) begin : g_cell
        rbrl_cell #(
            .P(BLOCK_BITS - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .prev_valid(stage_valid[i]),
            .prev_data (stage_data[i]),
            .valid_reg (stage_valid[i+1]),
            .data_reg  (stage_data[i+1])
        );
    end

    assign chain_result.rank = stage_data[BLOCK_BITS].rank;
    assign chain_result.bad  = stage_data[BLOCK_BITS].bad;

    rbrl_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[BLOCK_BITS]),
        .up_ready (en),
        .up_data  (chain_result),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_result)
    );

    assign in_ready    = en;
    assign rank_value  = out_result.rank;
    assign bad_request = out_result.bad;

endmodule

FILE: sv/rbrl_cell.sv
// One decode cell: resolves a single bit of the block and passes the state on.
module rbrl_cell #(
    parameter int P = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                prev_valid,
    input  rbrl_pkg::cell_data_t prev_data,
    output logic                valid_reg,
    output rbrl_pkg::cell_data_t data_reg
);

    logic [rbrl_pkg::BINOM_W-1:0] below_tbl [rbrl_pkg::CLASS_N];
    logic [rbrl_pkg::BINOM_W-1:0] below;
    logic                         take;
    logic                         counts;
    rbrl_pkg::cell_data_t         data_next;

    for (genvar k = 0; k < rbrl_pkg::CLASS_N; k++) begin : g_tbl
        assign below_tbl[k] = rbrl_pkg::binom_sat(P, k);
    end

    assign below  = below_tbl[prev_data.remaining];
    assign take   = (prev_data.remaining != '0) && ({1'b0, prev_data.offset} >= below);
    assign counts = {{(rbrl_pkg::IDX_W - rbrl_pkg::POS_W){1'b0}}, prev_data.pos}
                    >= rbrl_pkg::IDX_W'(P);

    always_comb begin
        data_next = prev_data;
        if (take) begin
            // below is under 2^13 here since the offset reached it
            data_next.offset    = prev_data.offset - below[rbrl_pkg::OFFSET_W-1:0];
            data_next.remaining = prev_data.remaining - 1'b1;
            if (counts) begin
                data_next.rank = prev_data.rank + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: sv/rbrl_out_buf.sv
// Output register with a skid entry; upstream ready comes straight from a flop.
module rbrl_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  rbrl_pkg::result_t up_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rbrl_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    rbrl_pkg::result_t out_data_reg;
    rbrl_pkg::result_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    rbrl_pkg::result_t skid_data_reg;
    rbrl_pkg::result_t skid_data_next;
    logic              in_fire;
    logic              out_fire;

    assign up_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = up_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_data_next  = up_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = up_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
